### rtl/rpn_pkg.sv
// rpn_pkg: shared constants, command and status codes, and the control/status
// structs that join the rpn controller and datapath
// no dependencies
package rpn_pkg;

  // stack geometry
  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned PTR_W       = $clog2(STACK_DEPTH + 1);

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  // stream word widths, rounded up to whole bytes
  localparam int unsigned IN_TDATA_W  = ((CMD_W + DATA_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((DATA_W + ST_W + 7) / 8) * 8;

  localparam logic [PTR_W-1:0] SP_FULL = PTR_W'(STACK_DEPTH);

  // token commands
  localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [ST_W-1:0] ST_DIVZERO   = 2'd3;

  // controller to datapath
  typedef struct packed {
    logic            accept;     // capture the incoming token
    logic            push;       // write operand at sp, sp + 1
    logic            rd_en;      // read stack into rd_data
    logic            rd_second;  // read at sp - 2 instead of sp - 1
    logic            cap_right;  // latch right operand from rd_data
    logic            alu_wr;     // write alu result at sp - 2, sp - 1
    logic            div_start;  // launch the divider
    logic            div_wr;     // write quotient at sp - 2, sp - 1
    logic            flag_en;    // record error if none yet
    logic [ST_W-1:0] flag_code;
    logic            clear;      // empty stack, clear error
    logic            emit;       // load the output register
  } rpn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic             last;
    logic             sp_empty;
    logic             sp_lt2;
    logic             sp_full;
    logic             right_zero;
    logic             div_done;
    logic             out_busy;
  } rpn_stat_t;

endpackage

### rtl/rpn_div.sv
// rpn_div: iterative signed divider, one quotient bit per cycle, truncating
// toward zero; depends on rpn_pkg
module rpn_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rpn_pkg::DATA_W-1:0]    dividend_i,
  input  logic [rpn_pkg::DATA_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [rpn_pkg::DATA_W-1:0]    quotient_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [rpn_pkg::CNT_W-1:0]    cnt_q;
  logic [rpn_pkg::DATA_W-1:0]   quo_q;
  logic [rpn_pkg::DATA_W-1:0]   rem_q;
  logic [rpn_pkg::DATA_W-1:0]   dvs_q;
  logic                         neg_q;

  logic [rpn_pkg::DATA_W-1:0]   dividend_abs;
  logic [rpn_pkg::DATA_W-1:0]   divisor_abs;
  logic [rpn_pkg::DATA_W:0]     rem_sh;
  logic [rpn_pkg::DATA_W:0]     diff;
  logic                         fits;

  assign dividend_abs = dividend_i[rpn_pkg::DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign divisor_abs  = divisor_i[rpn_pkg::DATA_W-1]  ? (~divisor_i + 1'b1)  : divisor_i;

  // shift-subtract step
  assign rem_sh = {rem_q, quo_q[rpn_pkg::DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign fits   = ~diff[rpn_pkg::DATA_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & ~start_i & (cnt_q == '0);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= rpn_pkg::CNT_W'(rpn_pkg::DATA_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_abs;
      rem_q <= '0;
      dvs_q <= divisor_abs;
      neg_q <= dividend_i[rpn_pkg::DATA_W-1] ^ divisor_i[rpn_pkg::DATA_W-1];
    end else if (busy_q) begin
      rem_q <= fits ? diff[rpn_pkg::DATA_W-1:0] : rem_sh[rpn_pkg::DATA_W-1:0];
      quo_q <= {quo_q[rpn_pkg::DATA_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (~quo_q + 1'b1) : quo_q;

endmodule

### rtl/rpn_ctrl.sv
// rpn_ctrl: token sequencer state machine for the rpn evaluator
// depends on rpn_pkg
module rpn_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  rpn_pkg::rpn_stat_t  stat_i,
  output rpn_pkg::rpn_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_RD_L,
    S_EXEC,
    S_DIV,
    S_LAST,
    S_TOP,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   is_op;

  assign is_op = (stat_i.command == rpn_pkg::CMD_ADD) || (stat_i.command == rpn_pkg::CMD_SUB) ||
                 (stat_i.command == rpn_pkg::CMD_MUL) || (stat_i.command == rpn_pkg::CMD_DIV);

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    state_d   = state_q;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (stat_i.command == rpn_pkg::CMD_PUSH) begin
          if (stat_i.sp_full) begin
            cmd_o.flag_en   = 1'b1;
            cmd_o.flag_code = rpn_pkg::ST_OVERFLOW;
          end else begin
            cmd_o.push = 1'b1;
          end
          state_d = S_LAST;
        end else if (is_op) begin
          if (stat_i.sp_lt2) begin
            cmd_o.flag_en   = 1'b1;
            cmd_o.flag_code = rpn_pkg::ST_UNDERFLOW;
            state_d         = S_LAST;
          end else begin
            cmd_o.rd_en = 1'b1;
            state_d     = S_RD_L;
          end
        end else begin
          state_d = S_LAST;
        end
      end
      S_RD_L: begin
        cmd_o.cap_right = 1'b1;
        cmd_o.rd_en     = 1'b1;
        cmd_o.rd_second = 1'b1;
        state_d         = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.command == rpn_pkg::CMD_DIV) begin
          if (stat_i.right_zero) begin
            cmd_o.flag_en   = 1'b1;
            cmd_o.flag_code = rpn_pkg::ST_DIVZERO;
            state_d         = S_LAST;
          end else begin
            cmd_o.div_start = 1'b1;
            state_d         = S_DIV;
          end
        end else begin
          cmd_o.alu_wr = 1'b1;
          state_d      = S_LAST;
        end
      end
      S_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d      = S_LAST;
        end
      end
      S_LAST: begin
        if (!stat_i.last) begin
          state_d = S_IDLE;
        end else begin
          if (stat_i.sp_empty) begin
            cmd_o.flag_en   = 1'b1;
            cmd_o.flag_code = rpn_pkg::ST_UNDERFLOW;
          end
          cmd_o.rd_en = 1'b1;
          state_d     = S_TOP;
        end
      end
      S_TOP: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit  = 1'b1;
          cmd_o.clear = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/rpn_dp.sv
// rpn_dp: operand stack memory, pointer, sticky status, alu, divider and
// output register; depends on rpn_pkg and rpn_div
module rpn_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rpn_pkg::rpn_cmd_t               cmd_i,
  output rpn_pkg::rpn_stat_t              stat_o,
  input  logic [rpn_pkg::CMD_W-1:0]       command_i,
  input  logic [rpn_pkg::DATA_W-1:0]      operand_value_i,
  input  logic                            last_token_i,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [rpn_pkg::DATA_W-1:0]      result_value_o,
  output logic [rpn_pkg::ST_W-1:0]        status_o
);

  logic [rpn_pkg::DATA_W-1:0]   stack_mem [rpn_pkg::STACK_DEPTH];

  logic [rpn_pkg::CMD_W-1:0]    cmd_q;
  logic [rpn_pkg::DATA_W-1:0]   val_q;
  logic                         last_q;
  logic [rpn_pkg::PTR_W-1:0]    sp_q, sp_d;
  logic [rpn_pkg::ST_W-1:0]     err_q, err_d;
  logic [rpn_pkg::DATA_W-1:0]   rd_data_q;
  logic [rpn_pkg::DATA_W-1:0]   right_q;
  logic                         out_valid_q;
  logic [rpn_pkg::DATA_W-1:0]   out_value_q;
  logic [rpn_pkg::ST_W-1:0]     out_status_q;

  logic [rpn_pkg::PTR_W-1:0]    sp_m1, sp_m2;
  logic [rpn_pkg::ADDR_W-1:0]   rd_addr, wr_addr;
  logic                         wr_en;
  logic [rpn_pkg::DATA_W-1:0]   wr_data;
  logic [rpn_pkg::DATA_W-1:0]   prod;
  logic [rpn_pkg::DATA_W-1:0]   alu_res;
  logic                         div_done;
  logic [rpn_pkg::DATA_W-1:0]   div_quo;

  assign sp_m1 = sp_q - 1'b1;
  assign sp_m2 = sp_q - 2'd2;

  // left operand is the last read, still held in rd_data_q
  assign prod = rd_data_q * right_q;

  always_comb begin
    unique case (cmd_q)
      rpn_pkg::CMD_ADD: alu_res = rd_data_q + right_q;
      rpn_pkg::CMD_SUB: alu_res = rd_data_q - right_q;
      rpn_pkg::CMD_MUL: alu_res = prod;
      default:          alu_res = '0;
    endcase
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (rd_data_q),
    .divisor_i  (right_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // stack memory, one write and one registered read port
  assign rd_addr = cmd_i.rd_second ? sp_m2[rpn_pkg::ADDR_W-1:0] : sp_m1[rpn_pkg::ADDR_W-1:0];
  assign wr_en   = cmd_i.push | cmd_i.alu_wr | cmd_i.div_wr;
  assign wr_addr = cmd_i.push ? sp_q[rpn_pkg::ADDR_W-1:0] : sp_m2[rpn_pkg::ADDR_W-1:0];
  assign wr_data = cmd_i.push ? val_q : (cmd_i.alu_wr ? alu_res : div_quo);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= stack_mem[rd_addr];
    end
  end

  // token, right operand and output register capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q  <= command_i;
      val_q  <= operand_value_i;
      last_q <= last_token_i;
    end
    if (cmd_i.cap_right) begin
      right_q <= rd_data_q;
    end
    if (cmd_i.emit) begin
      out_value_q  <= (err_q == rpn_pkg::ST_OK) ? rd_data_q : '0;
      out_status_q <= err_q;
    end
  end

  always_comb begin
    sp_d = sp_q;
    if (cmd_i.clear) begin
      sp_d = '0;
    end else if (cmd_i.push) begin
      sp_d = sp_q + 1'b1;
    end else if (cmd_i.alu_wr || cmd_i.div_wr) begin
      sp_d = sp_m1;
    end
  end

  always_comb begin
    err_d = err_q;
    if (cmd_i.clear) begin
      err_d = rpn_pkg::ST_OK;
    end else if (cmd_i.flag_en && (err_q == rpn_pkg::ST_OK)) begin
      err_d = cmd_i.flag_code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      err_q       <= rpn_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      sp_q  <= sp_d;
      err_q <= err_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.command    = cmd_q;
  assign stat_o.last       = last_q;
  assign stat_o.sp_empty   = (sp_q == '0);
  assign stat_o.sp_lt2     = (sp_q < rpn_pkg::PTR_W'(2));
  assign stat_o.sp_full    = (sp_q == rpn_pkg::SP_FULL);
  assign stat_o.right_zero = (right_q == '0);
  assign stat_o.div_done   = div_done;
  assign stat_o.out_busy   = out_valid_q & ~out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign status_o       = out_status_q;

  // stack pointer never passes the depth
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= rpn_pkg::SP_FULL)
    else $error("stack pointer beyond depth");

  // first error of an expression is kept until the result goes out
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != rpn_pkg::ST_OK && !cmd_i.clear) |=> err_q == $past(err_q))
    else $error("sticky error overwritten");

  // divider never launched on a zero divisor
  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> right_q != '0)
    else $error("divide started with zero divisor");

  // a pending result is never overwritten
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten");

endmodule

### rtl/rpn_stack_evaluator.sv
// rpn_stack_evaluator: top level of the reverse polish expression evaluator
// depends on rpn_pkg, rpn_ctrl, rpn_dp (and rpn_div below it)

// Evaluates a reverse polish expression streamed in one token per word.
// A push token stores a signed 32-bit operand on a 64-entry stack; add,
// subtract, multiply and divide pop the right then the left operand and push
// the result (two's complement wraparound, division truncates toward zero).
// The token with tlast set produces one result word: the top of stack, or
// zero with a nonzero status on stack underflow, stack overflow or divide by
// zero (first error of the expression wins); the stack and status are then
// cleared. Tokens are handled one at a time by a small sequencer around a
// stack memory with one write port and one registered read port: a push is
// decoded and written; add/sub/mul read the right then the left operand
// and write the result; divide waits on the divider (one quotient bit per
// cycle); a last token adds a top read and the output register load, plus
// any wait for a previous result still on m_axis. The output register frees
// the input side, so a new token is taken while a result still waits.
module rpn_stack_evaluator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // token input
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [2:0] command, [34:3] operand_value, rest zero
  input  logic [rpn_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // last_token
  input  logic                                s_axis_tlast,
  // result output
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [31:0] result_value, [33:32] status, rest zero
  output logic [rpn_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  rpn_pkg::rpn_cmd_t            cmd;
  rpn_pkg::rpn_stat_t           stat;
  logic [rpn_pkg::DATA_W-1:0]   result_value;
  logic [rpn_pkg::ST_W-1:0]     status;

  // sequencer: one token in flight, walks the stack accesses and the alu
  rpn_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  // stack, pointer, error, arithmetic and output register
  rpn_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .command_i       (s_axis_tdata[rpn_pkg::CMD_W-1:0]),
    .operand_value_i (s_axis_tdata[rpn_pkg::CMD_W+rpn_pkg::DATA_W-1:rpn_pkg::CMD_W]),
    .last_token_i    (s_axis_tlast),
    .out_ready_i     (m_axis_tready),
    .out_valid_o     (m_axis_tvalid),
    .result_value_o  (result_value),
    .status_o        (status)
  );

  // pack result word, padding bits zero
  assign m_axis_tdata = rpn_pkg::OUT_TDATA_W'({status, result_value});

endmodule

### test/tb_rpn_stack_evaluator.sv
// tb_rpn_stack_evaluator: self-checking testbench for the reverse polish evaluator,
// a directed token table (some outcomes typed in) then random expressions, checked
// against a local stack model; depends on rpn_pkg and rpn_stack_evaluator
module tb_rpn_stack_evaluator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TARGET_ITEMS = 550;
  localparam int unsigned LONG_HOLD    = 400;
  localparam int unsigned MAX_REPORTS  = 10;

  // commands the block ignores
  localparam logic [rpn_pkg::CMD_W-1:0] CMD_UNUSED5 = 3'd5;
  localparam logic [rpn_pkg::CMD_W-1:0] CMD_UNUSED6 = 3'd6;
  localparam logic [rpn_pkg::CMD_W-1:0] CMD_UNUSED7 = 3'd7;

  typedef struct packed {
    logic [rpn_pkg::CMD_W-1:0]  cmd;
    logic [rpn_pkg::DATA_W-1:0] val;
    logic                       last;
  } token_t;

  typedef struct packed {
    logic [rpn_pkg::DATA_W-1:0] val;
    logic [rpn_pkg::ST_W-1:0]   st;
  } outcome_t;

  // directed row: token plus an optional hand-written outcome
  typedef struct packed {
    logic [rpn_pkg::CMD_W-1:0]  cmd;
    logic [rpn_pkg::DATA_W-1:0] val;
    logic                       last;
    logic                       typed;
    logic [rpn_pkg::DATA_W-1:0] want_val;
    logic [rpn_pkg::ST_W-1:0]   want_st;
  } dir_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [rpn_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tlast;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [rpn_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // local copy of the evaluator state
  logic [rpn_pkg::DATA_W-1:0] eval_stack [rpn_pkg::STACK_DEPTH];
  int unsigned                depth_used;
  logic [rpn_pkg::ST_W-1:0]   first_err;

  outcome_t    pending_results [$];
  token_t      token_q [$];
  dir_row_t    dir_rows [25];

  int unsigned items_sent;
  int unsigned tokens_sent;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned status_seen [4];
  int unsigned hold_requests;
  int unsigned holds_done;
  int unsigned drains;
  int unsigned src_gap_pct;
  int unsigned burst_left;
  bit          src_offering;

  rpn_stack_evaluator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic void keep_first_error(input logic [rpn_pkg::ST_W-1:0] code);
    if (first_err == rpn_pkg::ST_OK) first_err = code;
  endfunction

  // advance the local stack by one token; returns 1 when a result is due
  function automatic bit eval_token(input token_t t, output outcome_t r);
    logic [rpn_pkg::DATA_W-1:0] lhs;
    logic [rpn_pkg::DATA_W-1:0] rhs;
    logic [rpn_pkg::DATA_W-1:0] res;
    longint                     quot;
    bit                         wr;
    r = '0;
    case (t.cmd)
      rpn_pkg::CMD_PUSH: begin
        if (depth_used >= rpn_pkg::STACK_DEPTH) begin
          keep_first_error(rpn_pkg::ST_OVERFLOW);
        end else begin
          eval_stack[depth_used] = t.val;
          depth_used++;
        end
      end
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV: begin
        if (depth_used < 2) begin
          keep_first_error(rpn_pkg::ST_UNDERFLOW);
        end else begin
          rhs = eval_stack[depth_used-1];
          lhs = eval_stack[depth_used-2];
          res = '0;
          wr  = 1'b1;
          case (t.cmd)
            rpn_pkg::CMD_ADD: res = lhs + rhs;
            rpn_pkg::CMD_SUB: res = lhs - rhs;
            rpn_pkg::CMD_MUL: res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                keep_first_error(rpn_pkg::ST_DIVZERO);
                wr = 1'b0;
              end else begin
                // 64-bit divide so min / -1 wraps instead of trapping
                quot = longint'($signed(lhs)) / longint'($signed(rhs));
                res  = quot[rpn_pkg::DATA_W-1:0];
              end
            end
          endcase
          if (wr) begin
            eval_stack[depth_used-2] = res;
            depth_used--;
          end
        end
      end
      default: ;
    endcase
    if (!t.last) return 1'b0;
    if (depth_used == 0) keep_first_error(rpn_pkg::ST_UNDERFLOW);
    if (first_err == rpn_pkg::ST_OK) r.val = eval_stack[depth_used-1];
    r.st       = first_err;
    depth_used = 0;
    first_err  = rpn_pkg::ST_OK;
    return 1'b1;
  endfunction

  function automatic logic [rpn_pkg::DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      5, 6:    return rpn_pkg::DATA_W'($signed($urandom_range(0, 200)) - 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rpn_pkg::CMD_W-1:0] rand_op();
    case ($urandom_range(0, 3))
      0:       return rpn_pkg::CMD_ADD;
      1:       return rpn_pkg::CMD_SUB;
      2:       return rpn_pkg::CMD_MUL;
      default: return rpn_pkg::CMD_DIV;
    endcase
  endfunction

  function automatic logic [rpn_pkg::CMD_W-1:0] rand_unused();
    case ($urandom_range(0, 2))
      0:       return CMD_UNUSED5;
      1:       return CMD_UNUSED6;
      default: return CMD_UNUSED7;
    endcase
  endfunction

  function automatic token_t make_token(input logic [rpn_pkg::CMD_W-1:0] cmd,
                                        input logic [rpn_pkg::DATA_W-1:0] val,
                                        input logic last);
    token_t t;
    t.cmd  = cmd;
    t.val  = val;
    t.last = last;
    return t;
  endfunction

  // valid expression with n operands, sometimes bent out of shape
  function automatic void build_expr(input int unsigned n);
    int unsigned pushed;
    int unsigned live;
    int unsigned idx;
    token_t      t;
    pushed = 0;
    live   = 0;
    token_q.delete();
    while (pushed < n || live > 1) begin
      if (pushed < n && (live < 2 || $urandom_range(0, 1) == 0)) begin
        token_q.push_back(make_token(rpn_pkg::CMD_PUSH, rand_operand(), 1'b0));
        pushed++;
        live++;
      end else begin
        token_q.push_back(make_token(rand_op(), $urandom, 1'b0));
        live--;
      end
    end
    if ($urandom_range(0, 99) < 20) begin
      idx = $urandom_range(0, token_q.size() - 1);
      case ($urandom_range(0, 3))
        0: token_q.insert(idx, make_token(rand_unused(), $urandom, 1'b0));
        1: token_q.insert(idx, make_token(rand_op(), $urandom, 1'b0));
        2: token_q.insert(idx, make_token(rpn_pkg::CMD_PUSH, rand_operand(), 1'b0));
        default: if (token_q.size() > 1) token_q.delete(idx);
      endcase
    end
    foreach (token_q[i]) token_q[i].last = 1'b0;
    t = token_q[token_q.size()-1];
    t.last = 1'b1;
    token_q[token_q.size()-1] = t;
  endfunction

  // long run of pushes, then operators, last on the final operator
  function automatic void build_deep(input int unsigned pushes, input int unsigned ops);
    token_q.delete();
    repeat (pushes) token_q.push_back(make_token(rpn_pkg::CMD_PUSH, rand_operand(), 1'b0));
    repeat (ops) token_q.push_back(make_token(rand_op(), $urandom, 1'b0));
    token_q[token_q.size()-1].last = 1'b1;
  endfunction

  // arbitrary tokens, any command, any last flag
  function automatic void build_noise();
    token_q.delete();
    repeat ($urandom_range(1, 6))
      token_q.push_back(make_token(rpn_pkg::CMD_W'($urandom_range(0, 7)), $urandom,
                                   $urandom_range(0, 3) == 0));
  endfunction

  function automatic int unsigned pick_gap();
    if (burst_left > 0 || src_gap_pct == 0) return 0;
    if ($urandom_range(0, 99) >= src_gap_pct) return 0;
    return ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
  endfunction

  // offer one word and predict once it is taken
  task automatic put_token(input token_t t, input bit typed, input outcome_t want);
    logic [rpn_pkg::IN_TDATA_W-1:0] word;
    outcome_t                       r;
    word = '0;
    word[rpn_pkg::CMD_W-1:0]                         = t.cmd;
    word[rpn_pkg::CMD_W+rpn_pkg::DATA_W-1:rpn_pkg::CMD_W] = t.val;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    s_axis_tlast  <= t.last;
    src_offering   = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    tokens_sent++;
    if (t.cmd <= rpn_pkg::CMD_DIV) items_sent++;
    if (eval_token(t, r)) pending_results.push_back(typed ? want : r);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic idle_after(input int unsigned gap, input bit drain);
    logic [63:0] junk;
    if (drain && gap == 0) gap = 1;
    if (gap > 0) begin
      junk = {$urandom, $urandom};
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= junk[rpn_pkg::IN_TDATA_W-1:0];
      s_axis_tlast  <= junk[63];
      src_offering   = 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain) begin
        wait_drained();
        drains++;
      end
    end
  endtask

  // results are compared with the oldest prediction
  always @(posedge clk_i) begin
    outcome_t                   want;
    logic [rpn_pkg::DATA_W-1:0] got_val;
    logic [rpn_pkg::ST_W-1:0]   got_st;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_val = m_axis_tdata[rpn_pkg::DATA_W-1:0];
      got_st  = m_axis_tdata[rpn_pkg::DATA_W+rpn_pkg::ST_W-1:rpn_pkg::DATA_W];
      results_seen++;
      status_seen[got_st]++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("[%0t] unexpected result word: value %h status %0d",
                   $realtime, got_val, got_st);
      end else begin
        want = pending_results.pop_front();
        if (got_val !== want.val || got_st !== want.st) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display({"[%0t] result mismatch: expected value %h status %0d,",
                      " got value %h status %0d"},
                     $realtime, want.val, want.st, got_val, got_st);
        end
      end
    end
  end

  // output side: random stalls, plus long hold-offs on request
  initial begin
    int unsigned stall_left;
    int unsigned sink_stall_pct;
    int unsigned cyc;
    stall_left     = 0;
    sink_stall_pct = 10;
    cyc            = 0;
    m_axis_tready  = 1'b0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 200 == 0) begin
        case ($urandom_range(0, 2))
          0:       sink_stall_pct = 0;
          1:       sink_stall_pct = 10;
          default: sink_stall_pct = 40;
        endcase
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (holds_done < hold_requests) begin
        stall_left = LONG_HOLD;
        holds_done++;
      end else if ($urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                 : $urandom_range(1, 3);
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned seq_no;
    dir_row_t    row;
    outcome_t    want;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    depth_used    = 0;
    first_err     = rpn_pkg::ST_OK;
    items_sent    = 0;
    tokens_sent   = 0;
    results_seen  = 0;
    mismatches    = 0;
    hold_requests = 0;
    holds_done    = 0;
    drains        = 0;
    src_gap_pct   = 10;
    burst_left    = 0;
    src_offering  = 1'b0;
    foreach (status_seen[i]) status_seen[i] = 0;

    dir_rows = '{
      // ignored command, then last on an empty stack
      '{CMD_UNUSED5,       32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_ADD,  32'h0,         1'b1, 1'b1, 32'h0,   rpn_pkg::ST_UNDERFLOW},
      // max + 1 wraps, operand of an operator ignored
      '{rpn_pkg::CMD_PUSH, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_PUSH, 32'h0000_0001, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_ADD,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'h8000_0000, rpn_pkg::ST_OK},
      // min / -1 wraps to min
      '{rpn_pkg::CMD_PUSH, 32'h8000_0000, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_PUSH, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_DIV,  32'h0,         1'b1, 1'b1, 32'h8000_0000, rpn_pkg::ST_OK},
      // zero divisor keeps both operands, a later underflow does not replace it
      '{rpn_pkg::CMD_PUSH, 32'h0000_0007, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_PUSH, 32'h0000_0000, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_DIV,  32'h0,         1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_SUB,  32'h0,         1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_MUL,  32'h0,         1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{CMD_UNUSED7,       32'h1234_5678, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{CMD_UNUSED6,       32'h0,         1'b1, 1'b1, 32'h0,   rpn_pkg::ST_DIVZERO},
      // negative quotient truncates toward zero
      '{rpn_pkg::CMD_PUSH, 32'hFFFF_FFF9, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_PUSH, 32'h0000_0002, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_DIV,  32'h0,         1'b1, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      // min * min, then a subtract into negative
      '{rpn_pkg::CMD_PUSH, 32'h8000_0000, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_PUSH, 32'h8000_0000, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_MUL,  32'h0,         1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_PUSH, 32'h0000_0001, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_SUB,  32'h0,         1'b1, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      // leftover entry below the top is dropped, push carries last
      '{rpn_pkg::CMD_PUSH, 32'h0000_0001, 1'b0, 1'b0, 32'h0,   rpn_pkg::ST_OK},
      '{rpn_pkg::CMD_PUSH, 32'h0000_0002, 1'b1, 1'b1, 32'h0000_0002, rpn_pkg::ST_OK}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      want.val = row.want_val;
      want.st  = row.want_st;
      put_token(make_token(row.cmd, row.val, row.last), row.typed, want);
      idle_after(pick_gap(), 1'b0);
    end

    seq_no = 0;
    want   = '0;
    while (tokens_sent < TARGET_ITEMS) begin
      seq_no++;
      case ($urandom_range(0, 2))
        0:       src_gap_pct = 0;
        1:       src_gap_pct = 8;
        default: src_gap_pct = 35;
      endcase
      // long output hold-off while short expressions keep coming
      if (seq_no == 5 || seq_no == 22) begin
        hold_requests++;
        burst_left = 10;
      end
      if (seq_no == 12) begin
        build_deep(rpn_pkg::STACK_DEPTH, rpn_pkg::STACK_DEPTH - 1);
      end else if (seq_no == 30) begin
        build_deep(rpn_pkg::STACK_DEPTH + 2, 3);
      end else if (burst_left > 0) begin
        build_expr($urandom_range(1, 3));
        burst_left--;
      end else if ($urandom_range(0, 99) < 12) begin
        build_noise();
      end else begin
        build_expr(($urandom_range(0, 7) == 0) ? $urandom_range(7, 12)
                                               : $urandom_range(1, 6));
      end
      foreach (token_q[i]) begin
        put_token(token_q[i], 1'b0, want);
        idle_after(pick_gap(), (seq_no % 20 == 0) && (i == token_q.size() - 1));
      end
    end

    if (src_offering) begin
      s_axis_tvalid <= 1'b0;
      src_offering   = 1'b0;
    end
    wait_drained();
    repeat (100) @(posedge clk_i);

    $display("run covered %0d tokens (%0d arithmetic or push), %0d results checked",
             tokens_sent, items_sent, results_seen);
    $display("status mix: ok %0d, underflow %0d, overflow %0d, div by zero %0d",
             status_seen[rpn_pkg::ST_OK], status_seen[rpn_pkg::ST_UNDERFLOW],
             status_seen[rpn_pkg::ST_OVERFLOW], status_seen[rpn_pkg::ST_DIVZERO]);
    $display("long output holds %0d, full drains %0d", holds_done, drains);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatches,
               pending_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
